@@ hdl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// expr holds at every sampled edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

`endif

@@ hdl/hsvct_pkg.sv @@
`timescale 1ns / 1ps
package hsvct_pkg;

	localparam int unsigned CH_W        = 8;
	localparam int unsigned HUE_W       = 13;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 13;

	localparam logic [HUE_W-1:0] HUE_FULL       = 13'd5760;
	localparam logic [HUE_W-1:0] HUE_BASE_RED   = 13'd0;
	localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 13'd1920;
	localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 13'd3840;

	localparam int unsigned QUOT_W        = 10;
	localparam int unsigned DIVIDEND_W    = 18;
	localparam int unsigned DIV_STEP_BITS = 2;
	localparam int unsigned DIV_STAGES    = QUOT_W / DIV_STEP_BITS;

	localparam int unsigned LUMA_SUM_W = 18;
	localparam int unsigned LUMA_SHIFT = 26;
	localparam logic [9:0]  LUMA_WR    = 10'd299;
	localparam logic [9:0]  LUMA_WG    = 10'd587;
	localparam logic [9:0]  LUMA_WB    = 10'd114;
	localparam logic [16:0] LUMA_RECIP = 17'd67109;

	localparam logic [CH_W-1:0] SAT_SCALE = 8'd255;

	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [HUE_W-1:0] hue_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_t;

	typedef struct packed {
		logic  match;
		chan_t post_red;
		chan_t post_green;
		chan_t post_blue;
		logic  hue_valid;
		hue_t  hue;
		chan_t luma;
	} result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HUE_A_LOW    = 3'd0,
		CFG_HUE_A_HIGH   = 3'd1,
		CFG_HUE_B_LOW    = 3'd2,
		CFG_HUE_B_HIGH   = 3'd3,
		CFG_MIN_SAT      = 3'd4,
		CFG_MIN_BRIGHT   = 3'd5,
		CFG_MIN_LUMA     = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		hue_t  hue_a_low;
		hue_t  hue_a_high;
		hue_t  hue_b_low;
		hue_t  hue_b_high;
		chan_t min_saturation;
		chan_t min_brightness;
		chan_t min_luma;
	} cfg_t;

	// travels alongside the hue divider
	typedef struct packed {
		pixel_t post;
		chan_t  luma;
		logic   pre_ok;
		logic   hue_valid;
		logic   neg;
		hue_t   base;
	} side_t;

	typedef struct packed {
		logic [DIVIDEND_W-1:0] rem;
		chan_t                 den;
		logic [QUOT_W-1:0]     quot;
		side_t                 side;
	} div_lane_t;

	function automatic chan_t max3(chan_t a, chan_t b, chan_t c);
		chan_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic chan_t min3(chan_t a, chan_t b, chan_t c);
		chan_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	// restoring division, DIV_STEP_BITS quotient bits starting at top_bit
	function automatic div_lane_t div_steps(div_lane_t l, int top_bit);
		div_lane_t             o;
		logic [DIVIDEND_W-1:0] trial;
		o = l;
		for (int j = 0; j < int'(DIV_STEP_BITS); j++) begin
			trial = DIVIDEND_W'(o.den) << (top_bit - j);
			if (o.rem >= trial) begin
				o.rem  = o.rem - trial;
				o.quot = {o.quot[QUOT_W-2:0], 1'b1};
			end else begin
				o.quot = {o.quot[QUOT_W-2:0], 1'b0};
			end
		end
		return o;
	endfunction

endpackage

@@ hdl/hsv_color_threshold_classifier.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Color class matcher: one RGB pixel per clock in while busy is low, one result per pixel out, in order.
// Each result appears for a single cycle on result with done high once its pixel, taken
// with start high and busy low, has passed every stage; the receiver cannot stall, so there
// is no backpressure. Ten stages: capture, posterize quotient and luma sum, posterize
// and thresholds, hue sector select, five hue divider stages of two quotient bits each,
// and the output register. busy is high only during reset and the cycle after it.
// Write configuration only when no pixel is in flight.
module hsv_color_threshold_classifier #(
	parameter int unsigned POSTER_STEP = 100
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  hsvct_pkg::pixel_t                  pixel,
	output logic                               done,
	output hsvct_pkg::result_t                 result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hsvct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hsvct_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned LATENCY = 4 + hsvct_pkg::DIV_STAGES + 1;

	hsvct_pkg::cfg_t       regs;
	logic                  busy_q;
	logic                  front_v, div_v;
	hsvct_pkg::div_lane_t  front_lane, div_lane;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b1;
		else         busy_q <= 1'b0;
	end

	assign busy = busy_q;

	hsvct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	hsvct_front #(
		.POSTER_STEP (POSTER_STEP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy_q),
		.in_pixel  (pixel),
		.regs      (regs),
		.out_valid (front_v),
		.out_lane  (front_lane)
	);

	hsvct_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_v),
		.in_lane   (front_lane),
		.out_valid (div_v),
		.out_lane  (div_lane)
	);

	// final hue: base plus the floored sector offset, or base minus the rounded-up offset, so the hue is floored
	hsvct_pkg::hue_t     hue_c, hue_f;
	logic                in_range, match_c;
	hsvct_pkg::result_t  res_c;

	always_comb begin
		if (div_lane.side.neg)
			hue_c = div_lane.side.base - hsvct_pkg::HUE_W'(div_lane.quot)
			      - hsvct_pkg::HUE_W'(div_lane.rem != '0);
		else
			hue_c = div_lane.side.base + hsvct_pkg::HUE_W'(div_lane.quot);
		hue_f    = div_lane.side.hue_valid ? hue_c : '0;
		in_range = (hue_f >= regs.hue_a_low && hue_f <= regs.hue_a_high)
		        || (hue_f >= regs.hue_b_low && hue_f <= regs.hue_b_high);
		match_c  = div_lane.side.hue_valid && in_range && div_lane.side.pre_ok;

		res_c.match      = match_c;
		res_c.post_red   = div_lane.side.post.red;
		res_c.post_green = div_lane.side.post.green;
		res_c.post_blue  = div_lane.side.post.blue;
		res_c.hue_valid  = div_lane.side.hue_valid;
		res_c.hue        = hue_f;
		res_c.luma       = div_lane.side.luma;
	end

	logic                v_s10;
	hsvct_pkg::result_t  res_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else         v_s10 <= div_v;
	end

	always_ff @(posedge clk) begin
		res_s10 <= res_c;
	end

	assign done   = v_s10;
	assign result = res_s10;

	`ASSERT_IMPLY(a_item_done, clk, arst_n, start && !busy, ##LATENCY done, "accepted item gives no result strobe at fixed latency")
	`ASSERT_IMPLY(a_done_item, clk, arst_n, done, $past(start && !busy, LATENCY), "result strobe without accepted item")
	`ASSERT_IMPLY(a_gray_no_hue, clk, arst_n, done && !result.hue_valid, result.hue == '0 && !result.match, "gray pixel with nonzero hue or match")
	`ASSERT_IMPLY(a_hue_bound, clk, arst_n, done, result.hue < hsvct_pkg::HUE_FULL, "hue out of range")

endmodule

@@ hdl/hsvct_cfg.sv @@
`timescale 1ns / 1ps
module hsvct_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hsvct_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hsvct_pkg::CFG_DATA_W-1:0]     cfg_data,
	output hsvct_pkg::cfg_t                      regs
);

	hsvct_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign regs      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_a_low      <= 13'd0;
			cfg_q.hue_a_high     <= 13'd480;
			cfg_q.hue_b_low      <= 13'd5440;
			cfg_q.hue_b_high     <= 13'd5760;
			cfg_q.min_saturation <= 8'd0;
			cfg_q.min_brightness <= 8'd0;
			cfg_q.min_luma       <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hsvct_pkg::CFG_HUE_A_LOW:  cfg_q.hue_a_low      <= cfg_data;
				hsvct_pkg::CFG_HUE_A_HIGH: cfg_q.hue_a_high     <= cfg_data;
				hsvct_pkg::CFG_HUE_B_LOW:  cfg_q.hue_b_low      <= cfg_data;
				hsvct_pkg::CFG_HUE_B_HIGH: cfg_q.hue_b_high     <= cfg_data;
				hsvct_pkg::CFG_MIN_SAT:    cfg_q.min_saturation <= cfg_data[7:0];
				hsvct_pkg::CFG_MIN_BRIGHT: cfg_q.min_brightness <= cfg_data[7:0];
				hsvct_pkg::CFG_MIN_LUMA:   cfg_q.min_luma       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/hsvct_front.sv @@
`timescale 1ns / 1ps
module hsvct_front #(
	parameter int unsigned POSTER_STEP = 100
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  hsvct_pkg::pixel_t     in_pixel,
	input  hsvct_pkg::cfg_t       regs,
	output logic                  out_valid,
	output hsvct_pkg::div_lane_t  out_lane
);

	localparam int unsigned RECIP_SHIFT = 18;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
	localparam logic [RECIP_W-1:0] POST_RECIP =
		RECIP_W'(((1 << RECIP_SHIFT) + POSTER_STEP - 1) / POSTER_STEP);
	localparam logic [7:0] STEP = 8'(POSTER_STEP);
	localparam int unsigned PQ_W = 8 + RECIP_W;
	localparam int unsigned LP_W = hsvct_pkg::LUMA_SUM_W + 17;

	// stage 1: input capture
	logic               v_s1;
	hsvct_pkg::pixel_t  pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		pix_s1 <= in_pixel;
	end

	// stage 2: quotients by step, luma sum, raw max / delta
	logic [PQ_W-1:0]                     prq_r, prq_g, prq_b;
	logic [hsvct_pkg::LUMA_SUM_W-1:0]    lsum_c;
	hsvct_pkg::chan_t                    rmx_c, rmn_c;

	assign prq_r  = PQ_W'(pix_s1.red)   * PQ_W'(POST_RECIP);
	assign prq_g  = PQ_W'(pix_s1.green) * PQ_W'(POST_RECIP);
	assign prq_b  = PQ_W'(pix_s1.blue)  * PQ_W'(POST_RECIP);
	assign lsum_c = hsvct_pkg::LUMA_SUM_W'(pix_s1.red)   * hsvct_pkg::LUMA_SUM_W'(hsvct_pkg::LUMA_WR)
	              + hsvct_pkg::LUMA_SUM_W'(pix_s1.green) * hsvct_pkg::LUMA_SUM_W'(hsvct_pkg::LUMA_WG)
	              + hsvct_pkg::LUMA_SUM_W'(pix_s1.blue)  * hsvct_pkg::LUMA_SUM_W'(hsvct_pkg::LUMA_WB);
	assign rmx_c  = hsvct_pkg::max3(pix_s1.red, pix_s1.green, pix_s1.blue);
	assign rmn_c  = hsvct_pkg::min3(pix_s1.red, pix_s1.green, pix_s1.blue);

	logic                              v_s2;
	hsvct_pkg::pixel_t                 quo_s2;
	logic [hsvct_pkg::LUMA_SUM_W-1:0]  lsum_s2;
	hsvct_pkg::chan_t                  mx_s2, dl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		quo_s2.red   <= prq_r[RECIP_SHIFT +: 8];
		quo_s2.green <= prq_g[RECIP_SHIFT +: 8];
		quo_s2.blue  <= prq_b[RECIP_SHIFT +: 8];
		lsum_s2      <= lsum_c;
		mx_s2        <= rmx_c;
		dl_s2        <= rmx_c - rmn_c;
	end

	// stage 3: posterized channels, luma, saturation and value tests
	logic [15:0]      pp_r, pp_g, pp_b, sat_l, sat_r;
	logic [LP_W-1:0]  lprod;
	logic             sat_ok_c;

	assign pp_r  = 16'(quo_s2.red)   * 16'(STEP);
	assign pp_g  = 16'(quo_s2.green) * 16'(STEP);
	assign pp_b  = 16'(quo_s2.blue)  * 16'(STEP);
	assign lprod = LP_W'(lsum_s2) * LP_W'(hsvct_pkg::LUMA_RECIP);
	assign sat_l = 16'(dl_s2) * 16'(hsvct_pkg::SAT_SCALE);
	assign sat_r = 16'(regs.min_saturation) * 16'(mx_s2);
	assign sat_ok_c = (mx_s2 == '0) ? (regs.min_saturation == '0) : (sat_l >= sat_r);

	logic               v_s3;
	hsvct_pkg::pixel_t  post_s3;
	hsvct_pkg::chan_t   luma_s3;
	logic               sat_ok_s3, bright_ok_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		post_s3.red   <= pp_r[7:0];
		post_s3.green <= pp_g[7:0];
		post_s3.blue  <= pp_b[7:0];
		luma_s3       <= lprod[hsvct_pkg::LUMA_SHIFT +: 8];
		sat_ok_s3     <= sat_ok_c;
		bright_ok_s3  <= (mx_s2 >= regs.min_brightness);
	end

	// stage 4: hue sector select and divider operands
	hsvct_pkg::chan_t      pmx, pmn, mag;
	logic signed [8:0]     diff;
	logic                  is_r, is_g;
	hsvct_pkg::hue_t       base;
	hsvct_pkg::div_lane_t  lane_c;

	assign pmx  = hsvct_pkg::max3(post_s3.red, post_s3.green, post_s3.blue);
	assign pmn  = hsvct_pkg::min3(post_s3.red, post_s3.green, post_s3.blue);
	assign is_r = (post_s3.red == pmx);
	assign is_g = !is_r && (post_s3.green == pmx);

	always_comb begin
		if (is_r) begin
			diff = $signed({1'b0, post_s3.green}) - $signed({1'b0, post_s3.blue});
			base = diff[8] ? hsvct_pkg::HUE_FULL : hsvct_pkg::HUE_BASE_RED;
		end else if (is_g) begin
			diff = $signed({1'b0, post_s3.blue}) - $signed({1'b0, post_s3.red});
			base = hsvct_pkg::HUE_BASE_GREEN;
		end else begin
			diff = $signed({1'b0, post_s3.red}) - $signed({1'b0, post_s3.green});
			base = hsvct_pkg::HUE_BASE_BLUE;
		end
		mag = diff[8] ? 8'(-diff) : diff[7:0];

		// dividend is 960 * |diff|
		lane_c.rem  = (hsvct_pkg::DIVIDEND_W'(mag) << 10) - (hsvct_pkg::DIVIDEND_W'(mag) << 6);
		lane_c.den  = pmx - pmn;
		lane_c.quot = '0;
		lane_c.side.post      = post_s3;
		lane_c.side.luma      = luma_s3;
		lane_c.side.pre_ok    = sat_ok_s3 && bright_ok_s3 && (luma_s3 >= regs.min_luma);
		lane_c.side.hue_valid = (pmx != pmn);
		lane_c.side.neg       = diff[8];
		lane_c.side.base      = base;
	end

	logic                  v_s4;
	hsvct_pkg::div_lane_t  lane_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		lane_s4 <= lane_c;
	end

	assign out_valid = v_s4;
	assign out_lane  = lane_s4;

endmodule

@@ hdl/hsvct_div.sv @@
`timescale 1ns / 1ps
module hsvct_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  hsvct_pkg::div_lane_t  in_lane,
	output logic                  out_valid,
	output hsvct_pkg::div_lane_t  out_lane
);

	hsvct_pkg::div_lane_t  lane_s  [hsvct_pkg::DIV_STAGES];
	logic                  valid_s [hsvct_pkg::DIV_STAGES];

	for (genvar k = 0; k < int'(hsvct_pkg::DIV_STAGES); k++) begin : g_stage
		hsvct_pkg::div_lane_t  stage_in;
		logic                  stage_v;

		if (k == 0) begin : g_first
			assign stage_in = in_lane;
			assign stage_v  = in_valid;
		end else begin : g_rest
			assign stage_in = lane_s[k-1];
			assign stage_v  = valid_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[k] <= 1'b0;
			else         valid_s[k] <= stage_v;
		end

		always_ff @(posedge clk) begin
			lane_s[k] <= hsvct_pkg::div_steps(stage_in,
				int'(hsvct_pkg::QUOT_W) - 1 - k * int'(hsvct_pkg::DIV_STEP_BITS));
		end
	end

	assign out_valid = valid_s[hsvct_pkg::DIV_STAGES-1];
	assign out_lane  = lane_s[hsvct_pkg::DIV_STAGES-1];

endmodule

@@ bench/tb_hsv_color_threshold_classifier.sv @@
`timescale 1ns / 1ps
module tb_hsv_color_threshold_classifier;

	localparam int unsigned POSTER_STEP = 100;
	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned TAIL_CYCLES = 12;
	localparam logic [hsvct_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

	class color_result_checker;
		hsvct_pkg::cfg_t    thresholds;
		hsvct_pkg::result_t pending_results[$];
		int                 mismatches;

		function new();
			thresholds.hue_a_low      = 13'd0;
			thresholds.hue_a_high     = 13'd480;
			thresholds.hue_b_low      = 13'd5440;
			thresholds.hue_b_high     = 13'd5760;
			thresholds.min_saturation = 8'd0;
			thresholds.min_brightness = 8'd0;
			thresholds.min_luma       = 8'd0;
			mismatches = 0;
		endfunction

		function void apply_write(logic [hsvct_pkg::CFG_IDX_W-1:0] idx,
			logic [hsvct_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				hsvct_pkg::CFG_HUE_A_LOW:  thresholds.hue_a_low      = d;
				hsvct_pkg::CFG_HUE_A_HIGH: thresholds.hue_a_high     = d;
				hsvct_pkg::CFG_HUE_B_LOW:  thresholds.hue_b_low      = d;
				hsvct_pkg::CFG_HUE_B_HIGH: thresholds.hue_b_high     = d;
				hsvct_pkg::CFG_MIN_SAT:    thresholds.min_saturation = d[7:0];
				hsvct_pkg::CFG_MIN_BRIGHT: thresholds.min_brightness = d[7:0];
				hsvct_pkg::CFG_MIN_LUMA:   thresholds.min_luma       = d[7:0];
				default: ;
			endcase
		endfunction

		function hsvct_pkg::result_t classify(hsvct_pkg::pixel_t p);
			hsvct_pkg::result_t res;
			int r, g, b, pr, pg, pb, pmax, pmin, pd, num, hue16;
			int rmax, rmin, rd, luma;
			bit sat_ok, in_range;
			r = p.red;
			g = p.green;
			b = p.blue;
			pr = (r / POSTER_STEP) * POSTER_STEP;
			pg = (g / POSTER_STEP) * POSTER_STEP;
			pb = (b / POSTER_STEP) * POSTER_STEP;
			pmax = pr;
			if (pg > pmax) pmax = pg;
			if (pb > pmax) pmax = pb;
			pmin = pr;
			if (pg < pmin) pmin = pg;
			if (pb < pmin) pmin = pb;
			pd = pmax - pmin;
			hue16 = 0;
			if (pd != 0) begin
				if (pr == pmax)
					num = 960 * (pg - pb);
				else if (pg == pmax)
					num = 1920 * pd + 960 * (pb - pr);
				else
					num = 3840 * pd + 960 * (pr - pg);
				if (num < 0)
					num = num + 5760 * pd;
				hue16 = num / pd;
			end
			luma = (299 * r + 587 * g + 114 * b) / 1000;
			rmax = r;
			if (g > rmax) rmax = g;
			if (b > rmax) rmax = b;
			rmin = r;
			if (g < rmin) rmin = g;
			if (b < rmin) rmin = b;
			rd = rmax - rmin;
			if (rmax == 0)
				sat_ok = (thresholds.min_saturation == 0);
			else
				sat_ok = (255 * rd >= int'(thresholds.min_saturation) * rmax);
			in_range = (hue16 >= int'(thresholds.hue_a_low) && hue16 <= int'(thresholds.hue_a_high)) ||
				(hue16 >= int'(thresholds.hue_b_low) && hue16 <= int'(thresholds.hue_b_high));
			res.match      = (pd != 0) && in_range && sat_ok &&
				(rmax >= int'(thresholds.min_brightness)) && (luma >= int'(thresholds.min_luma));
			res.post_red   = pr[7:0];
			res.post_green = pg[7:0];
			res.post_blue  = pb[7:0];
			res.hue_valid  = (pd != 0);
			res.hue        = hue16[12:0];
			res.luma       = luma[7:0];
			return res;
		endfunction

		function void take_pixel(hsvct_pkg::pixel_t p);
			pending_results.push_back(classify(p));
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(hsvct_pkg::result_t got);
			hsvct_pkg::result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: actual %h", $time, got);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("match", want.match, got.match);
				compare_field("post_red", want.post_red, got.post_red);
				compare_field("post_green", want.post_green, got.post_green);
				compare_field("post_blue", want.post_blue, got.post_blue);
				compare_field("hue_valid", want.hue_valid, got.hue_valid);
				compare_field("hue", want.hue, got.hue);
				compare_field("luma", want.luma, got.luma);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	hsvct_pkg::pixel_t                   pixel;
	logic                                done;
	hsvct_pkg::result_t                  result;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [hsvct_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [hsvct_pkg::CFG_DATA_W-1:0]    cfg_data;

	color_result_checker board;
	int unsigned         quiet_cycles;

	hsvct_pkg::chan_t edge_vals[6] = '{8'd0, 8'd99, 8'd100, 8'd199, 8'd200, 8'd255};
	hsvct_pkg::pixel_t corner_pixels[12] = '{
		'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
		'{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0},
		'{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd255}, '{8'd150, 8'd180, 8'd199},
		'{8'd200, 8'd0, 8'd100}, '{8'd255, 8'd199, 8'd0}, '{8'd1, 8'd0, 8'd0}
	};

	hsv_color_threshold_classifier #(
		.POSTER_STEP(POSTER_STEP)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.apply_write(cfg_index, cfg_data);
			if (start && !busy)
				board.take_pixel(pixel);
			if (done)
				board.check_result(result);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic hsvct_pkg::pixel_t rand_pixel();
		hsvct_pkg::pixel_t p;
		int     base, v, k;
		case ($urandom_range(0, 4))
			0, 1: begin
				p.red   = 8'($urandom_range(0, 255));
				p.green = 8'($urandom_range(0, 255));
				p.blue  = 8'($urandom_range(0, 255));
			end
			2: begin
				p.red   = edge_vals[$urandom_range(0, 5)];
				p.green = edge_vals[$urandom_range(0, 5)];
				p.blue  = edge_vals[$urandom_range(0, 5)];
			end
			3: begin
				base = $urandom_range(0, 255);
				p.red = 8'(base);
				for (k = 0; k < 2; k++) begin
					v = base + int'($urandom_range(0, 40)) - 20;
					if (v < 0) v = 0;
					if (v > 255) v = 255;
					if (k == 0) p.green = 8'(v);
					else p.blue = 8'(v);
				end
			end
			default: begin
				p.red   = 8'($urandom_range(0, 120));
				p.green = 8'($urandom_range(0, 120));
				p.blue  = 8'($urandom_range(0, 120));
				case ($urandom_range(0, 2))
					0: p.red = 8'($urandom_range(200, 255));
					1: p.green = 8'($urandom_range(200, 255));
					default: p.blue = 8'($urandom_range(200, 255));
				endcase
			end
		endcase
		return p;
	endfunction

	// an idle gap after about 22 percent of items keeps the sender idle ~18% of cycles
	task automatic send_pixel(input hsvct_pkg::pixel_t p, input bit allow_idle);
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
		if (allow_idle && $urandom_range(0, 99) < 22) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_pixels();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [hsvct_pkg::CFG_IDX_W-1:0] idx,
		input logic [hsvct_pkg::CFG_DATA_W-1:0] d);
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input int unsigned a_lo, a_hi, b_lo, b_hi, sat, bri, lum);
		drain_pixels();
		write_reg(CFG_IDX_SPARE, 13'($urandom));
		write_reg(hsvct_pkg::CFG_HUE_A_LOW, 13'(a_lo));
		write_reg(hsvct_pkg::CFG_HUE_A_HIGH, 13'(a_hi));
		write_reg(hsvct_pkg::CFG_HUE_B_LOW, 13'(b_lo));
		write_reg(hsvct_pkg::CFG_HUE_B_HIGH, 13'(b_hi));
		write_reg(hsvct_pkg::CFG_MIN_SAT, {5'($urandom), 8'(sat)});
		write_reg(hsvct_pkg::CFG_MIN_BRIGHT, {5'($urandom), 8'(bri)});
		write_reg(hsvct_pkg::CFG_MIN_LUMA, {5'($urandom), 8'(lum)});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_pixels(input int n, input bit allow_idle, input int pause_at);
		int i;
		for (i = 0; i < n; i++) begin
			if (i == pause_at)
				drain_pixels();
			send_pixel(rand_pixel(), allow_idle);
		end
	endtask

	task automatic run_corners();
		int i;
		for (i = 0; i < 12; i++)
			send_pixel(corner_pixels[i], 1'b1);
	endtask

	initial begin
		int unsigned a_lo, a_hi, b_lo, b_hi;
		int          ph;
		board = new();
		quiet_cycles = 0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		pixel     <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		run_corners();

		set_config(0, 5760, 0, 0, 0, 0, 0);
		run_pixels(100, 1'b1, -1);

		// empty and out-of-range hue windows, every minimum at full scale
		set_config(8191, 8191, 5760, 0, 255, 255, 255);
		run_corners();
		run_pixels(60, 1'b1, -1);

		set_config(0, 8191, 0, 8191, 255, 0, 0);
		run_pixels(80, 1'b1, -1);

		set_config(0, 0, 0, 0, 0, 255, 0);
		run_pixels(80, 1'b1, -1);

		for (ph = 0; ph < 6; ph++) begin
			a_lo = $urandom_range(0, 3000);
			a_hi = $urandom_range(a_lo, 5760);
			b_lo = $urandom_range(3000, 5760);
			b_hi = $urandom_range(b_lo, 8191);
			set_config(a_lo, a_hi, b_lo, b_hi, $urandom_range(0, 200),
				$urandom_range(0, 200), $urandom_range(0, 150));
			if (ph == 0)
				run_pixels(150, 1'b0, -1);
			else
				run_pixels(86, 1'b1, (ph == 1) ? 40 : -1);
		end

		drain_pixels();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
